### design/vlsa_pkg.sv
// ----------------------------------------------------------------------------
// vlsa_pkg
// Shared types and constants of the vehicle light strip animator.
// ----------------------------------------------------------------------------
package vlsa_pkg;

  localparam int STRIP_PIXELS = 32;
  localparam int PIX_W        = $clog2(STRIP_PIXELS);
  localparam int IDX_W        = 6;
  localparam int COLOR_W      = 24;
  localparam int NUM_SEGS     = 4;

  localparam logic [7:0] FILL_PHASE_BIT = 8'b0010_0000;
  localparam logic [7:0] FILL_MASK      = 8'b0011_1111;

  // operation codes of the input item
  localparam logic [1:0] OP_RENDER = 2'd0;
  localparam logic [1:0] OP_FLAG   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_BLINK  = 2'd3;

  // flag selectors
  localparam logic [2:0] FLAG_LEFT  = 3'd0;
  localparam logic [2:0] FLAG_RIGHT = 3'd1;
  localparam logic [2:0] FLAG_BRAKE = 3'd2;
  localparam logic [2:0] FLAG_HEAD  = 3'd3;
  localparam logic [2:0] FLAG_PARTY = 3'd4;

  // register indexes
  localparam logic [2:0] REG_OFFSETS = 3'd0;
  localparam logic [2:0] REG_LENGTHS = 3'd1;
  localparam logic [2:0] REG_IND     = 3'd2;
  localparam logic [2:0] REG_HEAD    = 3'd3;
  localparam logic [2:0] REG_TAIL    = 3'd4;
  localparam logic [2:0] REG_BRAKE   = 3'd5;
  localparam logic [2:0] REG_PARTY   = 3'd6;

  localparam logic [23:0] IND_RESET   = 24'hFFA500;
  localparam logic [23:0] HEAD_RESET  = 24'hFFFFFF;
  localparam logic [23:0] TAIL_RESET  = 24'h800000;
  localparam logic [23:0] BRAKE_RESET = 24'hFF0000;
  localparam logic [23:0] PARTY_RESET = 24'h0000FF;

  typedef enum logic [2:0] {
    CMD_RENDER,
    CMD_FLAG,
    CMD_CLEAR,
    CMD_BLINK,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [2:0]         sel;
    logic               val;
    logic [COLOR_W-1:0] bcol;
    logic               brev;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        offsets;
    logic [31:0]        lengths;
    logic [COLOR_W-1:0] ind;
    logic [COLOR_W-1:0] head;
    logic [COLOR_W-1:0] tail;
    logic [COLOR_W-1:0] brake;
    logic [COLOR_W-1:0] party;
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_SWEEP
  } back_state_e;

  // bit 1: pixel lies in the segment, bit 0: pixel lies in the colored part
  function automatic logic [1:0] seg_hit(input logic [PIX_W-1:0] p,
                                         input logic [7:0] off,
                                         input logic [7:0] len,
                                         input logic rev,
                                         input logic [7:0] num);
    logic [8:0] j;
    logic [7:0] m;
    logic       in_seg;
    logic       colored;
    j       = 9'(p) - {1'b0, off};
    m       = (num > len) ? len : num;
    in_seg  = (9'(p) >= {1'b0, off}) && (j < {1'b0, len});
    colored = rev ? (j >= {1'b0, len - m}) : (j < {1'b0, m});
    return {in_seg, in_seg & colored};
  endfunction

endpackage

### design/vlsa_if.sv
// ----------------------------------------------------------------------------
// vlsa_if
// Channel interfaces: input items, pixel results and register writes.
// ----------------------------------------------------------------------------
interface vlsa_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  flag_select;
  logic        flag_value;
  logic [23:0] blink_color;
  logic        blink_reverse;
  modport source (output valid, operation, flag_select, flag_value, blink_color,
                  blink_reverse, input ready);
  modport sink (input valid, operation, flag_select, flag_value, blink_color,
                blink_reverse, output ready);
endinterface

interface vlsa_pixel_if;
  logic        valid;
  logic        ready;
  logic [5:0]  pixel_index;
  logic [23:0] pixel_color;
  logic        last_pixel;
  modport source (output valid, pixel_index, pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_index, pixel_color, last_pixel, output ready);
endinterface

interface vlsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/vlsa_front.sv
// ----------------------------------------------------------------------------
// vlsa_front
// Accepts input items and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module vlsa_front import vlsa_pkg::*; (
  vlsa_item_if.sink item_i,
  output logic      push_o,
  output cmd_t      cmd_o,
  input  logic      full_i
);

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  always_comb begin
    cmd_o.sel  = item_i.flag_select;
    cmd_o.val  = item_i.flag_value;
    cmd_o.bcol = item_i.blink_color;
    cmd_o.brev = item_i.blink_reverse;
    unique case (item_i.operation)
      OP_RENDER: cmd_o.kind = CMD_RENDER;
      OP_FLAG:   cmd_o.kind = (item_i.flag_select > FLAG_PARTY) ? CMD_NOP : CMD_FLAG;
      OP_CLEAR:  cmd_o.kind = CMD_CLEAR;
      OP_BLINK:  cmd_o.kind = CMD_BLINK;
      default:   cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

### design/vlsa_queue.sv
// ----------------------------------------------------------------------------
// vlsa_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module vlsa_queue import vlsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = mem_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

### design/vlsa_back.sv
// ----------------------------------------------------------------------------
// vlsa_back
// Executes commands: owns flags, tick and frame buffer, sweeps pixels out.
// ----------------------------------------------------------------------------
module vlsa_back import vlsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_valid_i,
  input  cmd_t             q_cmd_i,
  output logic             pop_o,
  vlsa_pixel_if.source     pixel_o
);

  back_state_e        state_q, state_d;
  logic [COLOR_W-1:0] fb_q [STRIP_PIXELS];
  logic [7:0]         tick_q, tick_d;
  logic [4:0]         flags_q, flags_d;
  cmd_t               cur_q;
  logic [PIX_W-1:0]   p_q;
  logic [PIX_W-1:0]   bl_idx_q;
  logic               bl_hit_q, bl_wrap_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [COLOR_W-1:0] out_col_q;
  logic               out_last_q;

  logic               advance, last_p, start;
  logic [COLOR_W-1:0] pix_c;
  logic [9:0]         bl_sidx;
  logic [7:0]         tick_inc;
  logic [7:0]         flen;

  assign flen     = cfg_i.lengths[7:0];
  assign tick_inc = tick_q + 8'd1;
  assign last_p   = p_q == PIX_W'(STRIP_PIXELS - 1);
  assign bl_sidx  = q_cmd_i.brev ? ({2'b0, flen} - {2'b0, tick_q} - 10'd1)
                                 : {2'b0, tick_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (q_valid_i && (q_cmd_i.kind == CMD_RENDER || q_cmd_i.kind == CMD_CLEAR
                                 || q_cmd_i.kind == CMD_BLINK)) state_d = BK_SWEEP;
      BK_SWEEP: if (advance && last_p) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o   = state_q == BK_IDLE;
    start   = (state_q == BK_IDLE) && (state_d == BK_SWEEP);
    advance = (state_q == BK_SWEEP) && (!out_valid_q || pixel_o.ready);
  end

  // new color of pixel p_q for the current command
  always_comb begin
    logic [1:0]         hit;
    logic [7:0]         n;
    logic [7:0]         len;
    logic [COLOR_W-1:0] col;
    logic               side;
    pix_c = fb_q[p_q];
    n     = 8'd0;
    len   = 8'd0;
    col   = '0;
    side  = 1'b0;
    hit   = 2'b00;
    unique case (cur_q.kind)
      CMD_RENDER: begin
        for (int k = 0; k < NUM_SEGS; k++) begin
          side = (k < 2) ? flags_q[FLAG_LEFT] : flags_q[FLAG_RIGHT];
          if ((tick_q & FILL_PHASE_BIT) != 8'd0) begin
            n   = (tick_q << 1) & FILL_MASK;
            col = side ? cfg_i.ind : '0;
          end else begin
            n   = 8'hFF;
            col = '0;
          end
          hit = seg_hit(p_q, cfg_i.offsets[8*k +: 8], cfg_i.lengths[8*k +: 8],
                        (k == 0) || (k == 3), n);
          if (hit[1]) pix_c = hit[0] ? col : '0;
        end
        if (flags_q[FLAG_HEAD]) begin
          for (int k = 0; k < NUM_SEGS; k++) begin
            side = (k < 2) ? flags_q[FLAG_LEFT] : flags_q[FLAG_RIGHT];
            len  = cfg_i.lengths[8*k +: 8];
            col  = (k == 0 || k == 2) ? cfg_i.head : cfg_i.tail;
            hit  = seg_hit(p_q, cfg_i.offsets[8*k +: 8], len, (k == 0) || (k == 3),
                           len >> 1);
            if (!side && hit[1]) pix_c = hit[0] ? col : '0;
          end
        end
        if (flags_q[FLAG_BRAKE]) begin
          len = cfg_i.lengths[31:24];
          hit = seg_hit(p_q, cfg_i.offsets[31:24], len, 1'b1, len >> 1);
          if (hit[0]) pix_c = cfg_i.brake;
          len = cfg_i.lengths[15:8];
          hit = seg_hit(p_q, cfg_i.offsets[15:8], len, 1'b0, len >> 1);
          if (hit[0]) pix_c = cfg_i.brake;
        end
        if (flags_q[FLAG_PARTY] && (p_q == PIX_W'(tick_q % STRIP_PIXELS))) begin
          pix_c = cfg_i.party;
        end
      end
      CMD_CLEAR: pix_c = '0;
      CMD_BLINK: begin
        if (bl_hit_q && p_q == bl_idx_q) pix_c = cur_q.bcol;
        if (bl_wrap_q && 8'(p_q) <= flen) pix_c = '0;
      end
      default: pix_c = fb_q[p_q];
    endcase
  end

  always_comb begin
    tick_d  = tick_q;
    flags_d = flags_q;
    if (state_q == BK_IDLE && q_valid_i && q_cmd_i.kind == CMD_FLAG) begin
      flags_d[q_cmd_i.sel] = q_cmd_i.val;
      if (q_cmd_i.sel == FLAG_LEFT || q_cmd_i.sel == FLAG_RIGHT) tick_d = 8'd0;
    end else if (advance && last_p) begin
      unique case (cur_q.kind)
        CMD_RENDER: tick_d = tick_inc;
        CMD_CLEAR:  tick_d = 8'd0;
        CMD_BLINK:  tick_d = bl_wrap_q ? 8'd0 : tick_inc;
        default:    tick_d = tick_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      tick_q      <= 8'd0;
      flags_q     <= 5'd0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STRIP_PIXELS; i++) fb_q[i] <= '0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      flags_q <= flags_d;
      if (start) p_q <= '0;
      else if (advance) p_q <= p_q + PIX_W'(1);
      if (advance) begin
        fb_q[p_q]   <= pix_c;
        out_valid_q <= 1'b1;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q     <= q_cmd_i;
      bl_idx_q  <= bl_sidx[PIX_W-1:0];
      bl_hit_q  <= !bl_sidx[9] && (bl_sidx < 10'(STRIP_PIXELS));
      // the tick wraps to zero after 255 before the compare
      bl_wrap_q <= tick_inc > flen;
    end
    if (advance) begin
      out_idx_q  <= IDX_W'(p_q);
      out_col_q  <= pix_c;
      out_last_q <= last_p;
    end
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_index = out_idx_q;
  assign pixel_o.pixel_color = out_col_q;
  assign pixel_o.last_pixel  = out_last_q;

endmodule

### design/vehicle_light_strip_animator_top.sv
// ----------------------------------------------------------------------------
// vehicle_light_strip_animator_top
// Light strip animator: flags, tick and frame buffer, pixel stream out.
// ----------------------------------------------------------------------------
// Usage:
//   item_i  : operations (render, set flag, clear, blink step), valid/ready.
//   pixel_o : one transfer per pixel, index 0 first, last_pixel on the final one.
//   cfg_i   : register writes (index 0..6), always ready; write only while idle.
// A set-flag item produces no pixels and is retired by the back end while idle.
// Render, clear and blink items each sweep the frame buffer once, one pixel
// per cycle while the receiver keeps up; the item is taken as the back end
// enters the sweep state, and each pixel leaves through the output register.
// The sweep pace is set by the single frame-buffer pixel read/write per cycle.
// A two-entry command queue lets the front take items during a sweep.
// When the receiver stalls, the output register holds and the sweep pauses.
// Reset clears the frame buffer, tick and flags and loads default colors.
// ----------------------------------------------------------------------------
module vehicle_light_strip_animator_top import vlsa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  vlsa_item_if.sink    item_i,
  vlsa_pixel_if.source pixel_o,
  vlsa_cfg_if.sink     cfg_i
);

  cfg_t cfg_q;
  logic push, full, pop, q_valid;
  cmd_t f_cmd, q_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offsets <= '0;
      cfg_q.lengths <= '0;
      cfg_q.ind     <= IND_RESET;
      cfg_q.head    <= HEAD_RESET;
      cfg_q.tail    <= TAIL_RESET;
      cfg_q.brake   <= BRAKE_RESET;
      cfg_q.party   <= PARTY_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_OFFSETS: cfg_q.offsets <= cfg_i.data;
        REG_LENGTHS: cfg_q.lengths <= cfg_i.data;
        REG_IND:     cfg_q.ind     <= cfg_i.data[COLOR_W-1:0];
        REG_HEAD:    cfg_q.head    <= cfg_i.data[COLOR_W-1:0];
        REG_TAIL:    cfg_q.tail    <= cfg_i.data[COLOR_W-1:0];
        REG_BRAKE:   cfg_q.brake   <= cfg_i.data[COLOR_W-1:0];
        REG_PARTY:   cfg_q.party   <= cfg_i.data[COLOR_W-1:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  vlsa_front u_front (
    .item_i (item_i),
    .push_o (push),
    .cmd_o  (f_cmd),
    .full_i (full)
  );

  vlsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  vlsa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .pixel_o   (pixel_o)
  );

endmodule
